/* src/mbrx_pkg.sv */
// ----------------------------------------------------------------------------
// mbrx_pkg: shared types, constants and functions
// Frame-phase codes, payload memory geometry, write-request struct and the
// byte-wide CRC-16 update used by the read response receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrx_pkg;

    // Payload geometry: bytes per frame, packed eight to a memory row
    localparam int PAYLOAD_BYTES = 16;
    localparam int LANES         = 8;
    localparam int LANE_W        = 3;
    localparam int PAY_ROWS      = 2;
    localparam int ROW_W         = 1;
    localparam int ROW_BITS      = 8 * LANES;

    // Byte counter must reach PAYLOAD_BYTES + 1 (CRC high byte)
    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] CNT_CRC_LO = CNT_W'(PAYLOAD_BYTES);
    localparam logic [CNT_W-1:0] CNT_CRC_HI = CNT_W'(PAYLOAD_BYTES + 1);

    // Frame constants
    localparam logic [7:0]  READ_FUNCTION  = 8'h03;
    localparam logic [7:0]  BYTE_COUNT     = 8'(PAYLOAD_BYTES);
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [7:0]  SLAVE_ADDR_RST = 8'h01;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-1:0] REG_SLAVE_ADDR = 3'h0;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FUNC  = 2'd1,
        PH_COUNT = 2'd2,
        PH_BODY  = 2'd3
    } phase_t;

    // One byte-lane write into the payload memory
    typedef struct packed {
        logic              en;
        logic [ROW_W-1:0]  row;
        logic [LANE_W-1:0] lane;
        logic [7:0]        data;
    } pay_wr_t;

    // CRC-16, reflected, one byte per call
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Lanes at or beyond PAYLOAD_BYTES read as zero
    function automatic logic [PAY_ROWS*ROW_BITS-1:0] pay_mask();
        logic [PAY_ROWS*ROW_BITS-1:0] m;
        m = '0;
        for (int i = 0; i < PAY_ROWS * LANES; i++) begin
            m[i*8 +: 8] = (i < PAYLOAD_BYTES) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* src/mbrx_payload_mem.sv */
// ----------------------------------------------------------------------------
// mbrx_payload_mem: payload byte store
// Two rows of eight byte lanes, one lane written per cycle; both rows read
// together with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrx_payload_mem (
    input  wire logic                                   clk,
    input  wire mbrx_pkg::pay_wr_t                      wr,
    input  wire logic                                   rd_en,
    output logic       [mbrx_pkg::ROW_BITS-1:0]         rd_low,
    output logic       [mbrx_pkg::ROW_BITS-1:0]         rd_high
);

    logic [mbrx_pkg::ROW_BITS-1:0] mem [mbrx_pkg::PAY_ROWS];
    logic [mbrx_pkg::ROW_BITS-1:0] rd_low_reg;
    logic [mbrx_pkg::ROW_BITS-1:0] rd_high_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.row][{3'(wr.lane), 3'd0} +: 8] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_low_reg  <= mem[1'b0];
            rd_high_reg <= mem[1'b1];
        end
    end

    assign rd_low  = rd_low_reg;
    assign rd_high = rd_high_reg;

endmodule

`default_nettype wire

/* src/modbus_read_response_receiver_top.sv */
// ----------------------------------------------------------------------------
// modbus_read_response_receiver_top: read holding registers response parser
// Parses received bytes into a response frame, checks the CRC-16 on the fly
// and emits one result item per finished frame.
// ----------------------------------------------------------------------------
// Usage:
//   rx channel  : one received byte per item (rx_valid/rx_ready/rx_byte).
//   out channel : one item per finished frame (out_valid/out_ready) with
//                 frame_status (0 good CRC, 1 mismatch), payload_low,
//                 payload_high and the wrapping good frame count.
//   APB port    : register 0 at address 0 holds slave_address, the lowest
//                 first byte taken as a frame address; reads return it.
// Throughput: one byte per cycle; a CRC high byte may stall. The CRC update is an unrolled
//   eight-step XOR network; payload bytes go one lane per cycle into a two-row memory.
// Latency: the result item is valid the cycle after the CRC high byte is
//   accepted. Both payload rows are read when the CRC low byte arrives, so
//   the read latency of the memory is hidden.
// Reset: slave_address returns to 1, the parser goes idle, the good frame
//   count clears and no result is pending. The payload memory is not cleared;
//   every frame writes all of its bytes before its result is built.
// Receiver stall: a pending result holds in the output register. All bytes
//   are still accepted except a CRC high byte, which waits until the pending
//   item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_read_response_receiver_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // APB configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [mbrx_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [31:0]                        pwdata,
    output logic      [31:0]                        prdata,
    output logic                                    pready,
    // received byte channel
    input  wire logic                               rx_valid,
    output logic                                    rx_ready,
    input  wire logic [7:0]                         rx_byte,
    // result channel
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    frame_status,
    output logic      [63:0]                        payload_low,
    output logic      [63:0]                        payload_high,
    output logic      [15:0]                        good_frames
);

    localparam logic [mbrx_pkg::PAY_ROWS*mbrx_pkg::ROW_BITS-1:0] PAY_MASK =
        mbrx_pkg::pay_mask();

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [7:0] slave_addr_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr == mbrx_pkg::REG_SLAVE_ADDR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= mbrx_pkg::SLAVE_ADDR_RST;
        end
        else if (cfg_wr)
        begin
            slave_addr_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == mbrx_pkg::REG_SLAVE_ADDR)
        begin
            prdata = {24'h0, slave_addr_reg};
        end
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    mbrx_pkg::phase_t               phase_reg,    phase_next;
    logic [mbrx_pkg::CNT_W-1:0]     cnt_reg,      cnt_next;
    logic [15:0]                    crc_reg,      crc_next;
    logic [7:0]                     crc_lo_reg,   crc_lo_next;
    logic [15:0]                    good_cnt_reg, good_cnt_next;

    mbrx_pkg::pay_wr_t              pay_wr;
    logic                           pay_rd_en;
    logic [mbrx_pkg::ROW_BITS-1:0]  rd_low;
    logic [mbrx_pkg::ROW_BITS-1:0]  rd_high;

    logic                           is_final;
    logic                           in_fire;
    logic                           load_out;
    logic                           crc_good;
    logic [15:0]                    crc_upd;

    logic                           out_valid_reg;
    logic                           status_reg;
    logic [63:0]                    low_reg;
    logic [63:0]                    high_reg;
    logic [15:0]                    good_out_reg;

    // The CRC high byte completes a frame; hold it while a result is pending
    assign is_final = (phase_reg == mbrx_pkg::PH_BODY) && (cnt_reg == mbrx_pkg::CNT_CRC_HI);
    assign rx_ready = !is_final || !out_valid_reg || out_ready;
    assign in_fire  = rx_valid & rx_ready;
    assign load_out = in_fire & is_final;
    assign crc_upd  = mbrx_pkg::crc_feed(crc_reg, rx_byte);
    assign crc_good = (crc_lo_reg == crc_reg[7:0]) && (rx_byte == crc_reg[15:8]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= mbrx_pkg::PH_IDLE;
            cnt_reg      <= '0;
            crc_reg      <= mbrx_pkg::CRC_INIT;
            crc_lo_reg   <= '0;
            good_cnt_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            crc_reg      <= crc_next;
            crc_lo_reg   <= crc_lo_next;
            good_cnt_reg <= good_cnt_next;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        crc_next      = crc_reg;
        crc_lo_next   = crc_lo_reg;
        good_cnt_next = good_cnt_reg;
        pay_wr.en     = 1'b0;
        pay_wr.row    = cnt_reg[mbrx_pkg::LANE_W +: mbrx_pkg::ROW_W];
        pay_wr.lane   = cnt_reg[mbrx_pkg::LANE_W-1:0];
        pay_wr.data   = rx_byte;
        pay_rd_en     = 1'b0;

        case (phase_reg)
            mbrx_pkg::PH_IDLE:
            begin
                // drop bytes below the slave address
                if (in_fire && (rx_byte >= slave_addr_reg))
                begin
                    crc_next   = mbrx_pkg::crc_feed(mbrx_pkg::CRC_INIT, rx_byte);
                    cnt_next   = '0;
                    phase_next = mbrx_pkg::PH_FUNC;
                end
            end
            mbrx_pkg::PH_FUNC:
            begin
                if (in_fire)
                begin
                    if (rx_byte == mbrx_pkg::READ_FUNCTION)
                    begin
                        crc_next   = crc_upd;
                        phase_next = mbrx_pkg::PH_COUNT;
                    end
                    else
                    begin
                        phase_next = mbrx_pkg::PH_IDLE;
                    end
                end
            end
            mbrx_pkg::PH_COUNT:
            begin
                if (in_fire)
                begin
                    if (rx_byte == mbrx_pkg::BYTE_COUNT)
                    begin
                        crc_next   = crc_upd;
                        cnt_next   = '0;
                        phase_next = mbrx_pkg::PH_BODY;
                    end
                    else
                    begin
                        phase_next = mbrx_pkg::PH_IDLE;
                    end
                end
            end
            mbrx_pkg::PH_BODY:
            begin
                if (in_fire)
                begin
                    if (cnt_reg < mbrx_pkg::CNT_CRC_LO)
                    begin
                        // payload byte: store and fold into the CRC
                        pay_wr.en = 1'b1;
                        crc_next  = crc_upd;
                        cnt_next  = cnt_reg + 1'b1;
                    end
                    else if (cnt_reg == mbrx_pkg::CNT_CRC_LO)
                    begin
                        // CRC low byte: hold it and fetch both payload rows
                        crc_lo_next = rx_byte;
                        cnt_next    = cnt_reg + 1'b1;
                        pay_rd_en   = 1'b1;
                    end
                    else
                    begin
                        if (crc_good)
                        begin
                            good_cnt_next = good_cnt_reg + 16'd1;
                        end
                        cnt_next   = '0;
                        crc_next   = mbrx_pkg::CRC_INIT;
                        phase_next = mbrx_pkg::PH_IDLE;
                    end
                end
            end
            default:
            begin
                phase_next = mbrx_pkg::PH_IDLE;
            end
        endcase
    end

    mbrx_payload_mem u_payload_mem (
        .clk     (clk),
        .wr      (pay_wr),
        .rd_en   (pay_rd_en),
        .rd_low  (rd_low),
        .rd_high (rd_high)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg   <= !crc_good;
            low_reg      <= rd_low & PAY_MASK[mbrx_pkg::ROW_BITS-1:0];
            high_reg     <= rd_high & PAY_MASK[mbrx_pkg::PAY_ROWS*mbrx_pkg::ROW_BITS-1:
                                               mbrx_pkg::ROW_BITS];
            good_out_reg <= good_cnt_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_status = status_reg;
    assign payload_low  = low_reg;
    assign payload_high = high_reg;
    assign good_frames  = good_out_reg;

`ifndef SYNTH
    // A new result never overwrites one that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending item");

    // Byte counter never runs past the CRC high byte
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= mbrx_pkg::CNT_CRC_HI)
        else $error("byte counter out of range");

    // Payload rows are fetched exactly one byte before the frame ends
    a_rd_before_final: assert property (@(posedge clk) disable iff (!rst_n)
        pay_rd_en |=> is_final)
        else $error("payload read not followed by the CRC high byte phase");

    // Good count moves only on a frame with matching CRC
    a_good_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        !(load_out && crc_good) |=> $stable(good_cnt_reg))
        else $error("good frame count changed without a good frame");

    // A delivered good frame reports the count after its increment
    a_good_out: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && crc_good) |=> (out_valid_reg && !status_reg
                                    && (good_out_reg == good_cnt_reg)))
        else $error("good frame result inconsistent with counter");
`endif

endmodule

`default_nettype wire
